// File: design/pss_pkg.sv
`default_nettype none

package pss_pkg;

    localparam int DEPTH  = 64;
    localparam int GRP    = 8;
    localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
    localparam int PAD    = NGRP * GRP;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int GIX_W  = $clog2(GRP);
    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 8;
    localparam int OUT_W  = 7;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int IN_W   = 24;
    localparam int RES_W  = 24;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    typedef struct packed {
        logic             capture;
        logic             ins;
        logic             del;
        logic [VAL_W-1:0] key;
        logic [IDX_W-1:0] p0;
        logic [CNT_W-1:0] cnt;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/pss_cell.sv
`default_nettype none

module pss_cell (
    input  wire logic                     clk,
    input  wire pss_pkg::cell_ctrl_t      ctrl,
    input  wire logic [pss_pkg::IDX_W-1:0] idx,
    input  wire logic [pss_pkg::VAL_W-1:0] left_data,
    input  wire logic [pss_pkg::VAL_W-1:0] right_data,
    output logic      [pss_pkg::VAL_W-1:0] data,
    output logic                          match,
    output logic                          sel
);
    import pss_pkg::*;

    logic [VAL_W-1:0] data_reg, data_next;
    logic             match_reg, match_next;
    logic             sel_reg, sel_next;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        sel_next   = sel_reg;
        if (ctrl.capture)
        begin
            match_next = (data_reg == ctrl.key) && (CNT_W'(idx) < ctrl.cnt);
            sel_next   = (idx == ctrl.p0);
        end
        priority if (ctrl.ins && (idx > ctrl.p0))
            data_next = left_data;
        else if (ctrl.ins && (idx == ctrl.p0))
            data_next = ctrl.key;
        else if (ctrl.del && (idx >= ctrl.p0))
            data_next = right_data;
        else
            data_next = data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
        sel_reg   <= sel_next;
    end

    assign data  = data_reg;
    assign match = match_reg;
    assign sel   = sel_reg;

endmodule

`default_nettype wire

// File: design/pss_reduce.sv
`default_nettype none

module pss_reduce (
    input  wire logic                                  clk,
    input  wire logic [pss_pkg::DEPTH-1:0]             match,
    input  wire logic [pss_pkg::DEPTH-1:0]             sel,
    input  wire logic [pss_pkg::DEPTH-1:0][pss_pkg::VAL_W-1:0] data,
    output logic                                       any,
    output logic      [pss_pkg::CNT_W-1:0]             found,
    output logic      [pss_pkg::VAL_W-1:0]             rdata
);
    import pss_pkg::*;

    logic [PAD-1:0]             match_pad;
    logic [PAD-1:0]             sel_pad;
    logic [PAD-1:0][VAL_W-1:0]  data_pad;

    logic [NGRP-1:0]             gany_reg, gany_next;
    logic [NGRP-1:0][GIX_W-1:0]  gidx_reg, gidx_next;
    logic [NGRP-1:0][VAL_W-1:0]  gdat_reg, gdat_next;

    always_comb
    begin
        for (int j = 0; j < PAD; j++)
        begin
            if (j < DEPTH)
            begin
                match_pad[j] = match[j];
                sel_pad[j]   = sel[j];
                data_pad[j]  = data[j];
            end
            else
            begin
                match_pad[j] = 1'b0;
                sel_pad[j]   = 1'b0;
                data_pad[j]  = '0;
            end
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            gany_next[g] = 1'b0;
            gidx_next[g] = '0;
            gdat_next[g] = '0;
            for (int j = GRP - 1; j >= 0; j--)
            begin
                if (match_pad[g*GRP + j])
                begin
                    gany_next[g] = 1'b1;
                    gidx_next[g] = GIX_W'(j);
                end
                gdat_next[g] = gdat_next[g] | (data_pad[g*GRP + j] & {VAL_W{sel_pad[g*GRP + j]}});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gany_reg <= gany_next;
        gidx_reg <= gidx_next;
        gdat_reg <= gdat_next;
    end

    always_comb
    begin
        any   = 1'b0;
        found = '0;
        rdata = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (gany_reg[g])
            begin
                any   = 1'b1;
                found = CNT_W'(g * GRP) + CNT_W'(gidx_reg[g]) + CNT_W'(1);
            end
            rdata = rdata | gdat_reg[g];
        end
    end

endmodule

`default_nettype wire

// File: design/positional_sequence_store_top.sv
// Channel   Dir  Width  Fields (lowest bit first)
// s_axis    in   24     command[2:0], position[9:3], item_value[17:10], zero
// m_axis    out  24     ok[0], read_value[8:1], found_position[15:9],
//                       length[22:16], is_empty[23]
// Each command passes through accept (cells register compare and select
// flags), group reduction of the 64 flags, then commit (shift the cell chain,
// update the length, load the result register).
// One command at a time; the next is accepted right after commit.
// Commit waits while a prior result is still held by m_axis.
// rst_n clears control state; cell contents are undefined until written.
`default_nettype none

module positional_sequence_store_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // command, position, item_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata   // ok, read_value, found_position, length, is_empty
);
    import pss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EVAL   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CMD_W-1:0] cmd_reg;
    logic [VAL_W-1:0] value_reg;
    logic [IDX_W-1:0] p0_reg;
    logic             ok_reg;
    logic             out_valid_reg, out_valid_next;
    logic [RES_W-1:0] out_data_reg;

    logic [CMD_W-1:0] in_cmd;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    logic [CMP_W-1:0] pos_w, cnt_w;
    logic             pos_ge1, in_ok;
    logic [IDX_W-1:0] in_p0;
    logic             accept, commit;

    cell_ctrl_t                 ctrl;
    logic [DEPTH-1:0][VAL_W-1:0] cell_data;
    logic [DEPTH-1:0]           cell_match;
    logic [DEPTH-1:0]           cell_sel;

    logic             red_any;
    logic [CNT_W-1:0] red_found;
    logic [VAL_W-1:0] red_rdata;

    logic             res_ok;
    logic [VAL_W-1:0] res_rd;
    logic [OUT_W-1:0] res_found;
    logic [RES_W-1:0] res_word;

    assign in_cmd  = s_tdata[2:0];
    assign in_pos  = s_tdata[9:3];
    assign in_val  = s_tdata[17:10];
    assign pos_w   = CMP_W'(in_pos);
    assign cnt_w   = CMP_W'(count_reg);
    assign pos_ge1 = (in_pos != '0);
    assign in_p0   = IDX_W'(in_pos - POS_W'(1));

    always_comb
    begin
        in_ok = 1'b0;
        unique case (in_cmd)
            CMD_INSERT: in_ok = pos_ge1 && (pos_w <= cnt_w + CMP_W'(1))
                                && (cnt_w < CMP_W'(DEPTH));
            CMD_DELETE: in_ok = pos_ge1 && (pos_w <= cnt_w);
            CMD_GET:    in_ok = pos_ge1 && (pos_w <= cnt_w);
            CMD_LOCATE: in_ok = 1'b1;
            CMD_CLEAR:  in_ok = 1'b1;
            default:    in_ok = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_COMMIT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        ctrl.capture = accept;
        ctrl.ins     = commit && ok_reg && (cmd_reg == CMD_INSERT);
        ctrl.del     = commit && ok_reg && (cmd_reg == CMD_DELETE);
        ctrl.key     = accept ? in_val : value_reg;
        ctrl.p0      = accept ? in_p0 : p0_reg;
        ctrl.cnt     = count_reg;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_d, right_d;
        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
        end
        pss_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .idx        (IDX_W'(i)),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (cell_match[i]),
            .sel        (cell_sel[i])
        );
    end

    pss_reduce u_reduce (
        .clk   (clk),
        .match (cell_match),
        .sel   (cell_sel),
        .data  (cell_data),
        .any   (red_any),
        .found (red_found),
        .rdata (red_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (commit && ok_reg)
        begin
            unique case (cmd_reg)
                CMD_INSERT: count_next = count_reg + CNT_W'(1);
                CMD_DELETE: count_next = count_reg - CNT_W'(1);
                CMD_CLEAR:  count_next = '0;
                default:    count_next = count_reg;
            endcase
        end
    end

    always_comb
    begin
        res_ok    = ok_reg;
        res_rd    = (ok_reg && (cmd_reg == CMD_GET || cmd_reg == CMD_DELETE))
                    ? red_rdata : '0;
        res_found = ((cmd_reg == CMD_LOCATE) && red_any) ? OUT_W'(red_found) : '0;
        res_word  = {(count_next == '0), OUT_W'(count_next), res_found, res_rd, res_ok};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_EVAL;
            ST_EVAL:   state_next = ST_COMMIT;
            ST_COMMIT: if (commit) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= in_cmd;
            value_reg <= in_val;
            p0_reg    <= in_p0;
            ok_reg    <= in_ok;
        end
        if (commit)
            out_data_reg <= res_word;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("length exceeds depth");

    a_eval_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |=> state_reg == ST_COMMIT)
        else $error("evaluation did not advance to commit");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && ok_reg && cmd_reg == CMD_INSERT) |=>
            count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow length");

    a_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("length changed outside commit");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23] == (m_tdata[22:16] == '0)))
        else $error("empty flag disagrees with length");
`endif

endmodule

`default_nettype wire

// File: test/sequence_store_checker.sv
`default_nettype none

module sequence_store_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,  // command, position, item_value
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,  // ok, read_value, found_position, length, is_empty
    output int               errors,
    output int               pending
);
    import pss_pkg::*;

    typedef struct packed {
        logic [5:0]       pad;
        logic [VAL_W-1:0] item_value;
        logic [POS_W-1:0] position;
        logic [CMD_W-1:0] command;
    } seq_cmd_t;

    typedef struct packed {
        logic             is_empty;
        logic [OUT_W-1:0] len;
        logic [OUT_W-1:0] found_position;
        logic [VAL_W-1:0] read_value;
        logic             ok;
    } seq_result_t;

    logic [VAL_W-1:0] stored_bytes[$];
    seq_result_t      expected_results[$];

    function automatic seq_result_t apply_sequence_command(seq_cmd_t c);
        seq_result_t r;
        int          n;
        int          p;
        logic        hit;
        r   = '0;
        n   = stored_bytes.size();
        p   = int'(c.position);
        hit = 1'b0;
        case (c.command)
            CMD_INSERT:
            begin
                if (p >= 1 && p <= n + 1 && n < DEPTH)
                begin
                    stored_bytes.insert(p - 1, c.item_value);
                    r.ok = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (p >= 1 && p <= n)
                begin
                    r.read_value = stored_bytes[p - 1];
                    stored_bytes.delete(p - 1);
                    r.ok = 1'b1;
                end
            end
            CMD_GET:
            begin
                if (p >= 1 && p <= n)
                begin
                    r.read_value = stored_bytes[p - 1];
                    r.ok = 1'b1;
                end
            end
            CMD_LOCATE:
            begin
                r.ok = 1'b1;
                for (int k = 0; k < n; k++)
                begin
                    if (!hit && stored_bytes[k] == c.item_value)
                    begin
                        hit              = 1'b1;
                        r.found_position = OUT_W'(k + 1);
                    end
                end
            end
            CMD_CLEAR:
            begin
                stored_bytes.delete();
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.len      = OUT_W'(stored_bytes.size());
        r.is_empty = (stored_bytes.size() == 0);
        return r;
    endfunction

    task automatic compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seq_result_t exp_r;
        seq_result_t act_r;
        if (!rst_n)
        begin
            stored_bytes.delete();
            expected_results.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                act_r = m_tdata;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction: expected none, actual %06h",
                             $time, m_tdata);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    compare_field("ok", int'(exp_r.ok), int'(act_r.ok));
                    compare_field("read_value", int'(exp_r.read_value),
                                  int'(act_r.read_value));
                    compare_field("found_position", int'(exp_r.found_position),
                                  int'(act_r.found_position));
                    compare_field("length", int'(exp_r.len), int'(act_r.len));
                    compare_field("is_empty", int'(exp_r.is_empty), int'(act_r.is_empty));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_sequence_command(s_tdata));
            pending <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

// File: test/positional_sequence_store_top_tb.sv
`default_nettype none

module positional_sequence_store_top_tb;

    import pss_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 530;
    localparam int BURST_FIRST  = 250;
    localparam int BURST_LAST   = 330;
    localparam int CMD_TOP      = (1 << CMD_W) - 1;
    localparam int POS_TOP      = (1 << POS_W) - 1;
    localparam int VAL_TOP      = (1 << VAL_W) - 1;

    localparam logic [CMD_W-1:0] CMD_BAD_LO  = CMD_CLEAR + 3'd1;
    localparam logic [CMD_W-1:0] CMD_BAD_MID = CMD_CLEAR + 3'd2;
    localparam logic [CMD_W-1:0] CMD_BAD_HI  = CMD_W'(CMD_TOP);

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int errors;
    int pending;
    int sent_cnt = 0;
    int stim_len = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    int hold_idx = 0;

    positional_sequence_store_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sequence_store_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic in_burst(int n);
        return n >= BURST_FIRST && n < BURST_LAST;
    endfunction

    // receiver: random stalls, two long hold-offs while the sender keeps offering
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_idx < 2 && sent_cnt >= ((hold_idx == 0) ? 150 : 420))
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_idx <= hold_idx + 1;
        end
        else if (in_burst(sent_cnt))
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 35);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("positional_sequence_store_top_tb: FAIL");
            $finish;
        end
    end

    task automatic send_command(logic [CMD_W-1:0] cmd, int pos, int val);
        logic [POS_W-1:0] p;
        p = POS_W'(pos);
        while (!in_burst(sent_cnt) && $urandom_range(0, 99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, VAL_W'(val), p, cmd};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        sent_cnt <= sent_cnt + 1;
        // track the length to steer positions into the valid range
        case (cmd)
            CMD_INSERT:
                if (p >= 1 && p <= stim_len + 1 && stim_len < DEPTH)
                    stim_len = stim_len + 1;
            CMD_DELETE:
                if (p >= 1 && p <= stim_len)
                    stim_len = stim_len - 1;
            CMD_CLEAR:
                stim_len = 0;
            default: ;
        endcase
    endtask

    initial
    begin
        int               roll;
        int               phase;
        int               pos;
        int               val;
        logic [CMD_W-1:0] cmd;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_LOCATE, 0, 0);
        send_command(CMD_GET, 1, 0);
        send_command(CMD_DELETE, 0, 0);
        send_command(CMD_INSERT, 0, 8'h11);
        send_command(CMD_INSERT, 2, 8'h22);
        send_command(CMD_INSERT, 1, VAL_TOP);
        send_command(CMD_INSERT, 1, 0);
        send_command(CMD_INSERT, 3, 8'hA5);
        send_command(CMD_INSERT, 2, 8'h5A);
        send_command(CMD_INSERT, POS_TOP, 8'h3C);
        send_command(CMD_GET, 1, 0);
        send_command(CMD_GET, 4, 0);
        send_command(CMD_GET, 5, 0);
        send_command(CMD_GET, POS_TOP, VAL_TOP);
        send_command(CMD_LOCATE, 0, 8'hA5);
        send_command(CMD_LOCATE, 0, 8'h77);
        send_command(CMD_DELETE, 2, 0);
        send_command(CMD_DELETE, 3, 0);
        send_command(CMD_DELETE, 4, 0);
        send_command(CMD_BAD_LO, POS_TOP, VAL_TOP);
        send_command(CMD_BAD_MID, 1, 8'h5A);
        send_command(CMD_BAD_HI, 0, 0);
        send_command(CMD_CLEAR, POS_TOP, VAL_TOP);
        send_command(CMD_LOCATE, 0, 0);
        send_command(CMD_DELETE, 1, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase = (i / 70) % 4;
            roll  = $urandom_range(0, 99);
            // grow, mixed, grow to full, shrink
            if (phase == 0 || phase == 2)
                cmd = (roll < 80) ? CMD_INSERT : (roll < 85) ? CMD_DELETE :
                      (roll < 90) ? CMD_GET : (roll < 96) ? CMD_LOCATE :
                      (roll < 98) ? CMD_CLEAR : CMD_W'($urandom_range(CMD_BAD_LO, CMD_TOP));
            else if (phase == 1)
                cmd = (roll < 30) ? CMD_INSERT : (roll < 55) ? CMD_DELETE :
                      (roll < 75) ? CMD_GET : (roll < 95) ? CMD_LOCATE :
                      (roll < 97) ? CMD_CLEAR : CMD_W'($urandom_range(CMD_BAD_LO, CMD_TOP));
            else
                cmd = (roll < 15) ? CMD_INSERT : (roll < 75) ? CMD_DELETE :
                      (roll < 85) ? CMD_GET : (roll < 96) ? CMD_LOCATE :
                      (roll < 98) ? CMD_CLEAR : CMD_W'($urandom_range(CMD_BAD_LO, CMD_TOP));

            roll = $urandom_range(0, 99);
            if (roll < 80)
                pos = (cmd == CMD_INSERT) ? $urandom_range(1, stim_len + 1) :
                      (stim_len > 0) ? $urandom_range(1, stim_len) : 1;
            else if (roll < 90)
                pos = $urandom_range(0, 2) == 0 ? 0 : stim_len + $urandom_range(1, 2);
            else
                pos = $urandom_range(0, POS_TOP);

            val = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) :
                  $urandom_range(0, VAL_TOP);
            send_command(cmd, pos, val);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("positional_sequence_store_top_tb: PASS");
        else
            $display("positional_sequence_store_top_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
design/pss_pkg.sv
design/pss_cell.sv
design/pss_reduce.sv
design/positional_sequence_store_top.sv
test/sequence_store_checker.sv
test/positional_sequence_store_top_tb.sv
